[rtl/dlfb_pkg.sv]
package dlfb_pkg;

  localparam int unsigned IN_SIZE_DEF  = 16;
  localparam int unsigned OUT_SIZE_DEF = 16;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 24;

  localparam logic [VAL_W-1:0] LR_RESET = 16'd655;

  localparam logic [OP_W-1:0] OP_LOAD_W = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_FWD    = 2'd2;
  localparam logic [OP_W-1:0] OP_BWD    = 2'd3;

  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_BWD = 1'b1;

  // One classified input item; hit says that its index lies inside the store.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    hit;
  } item_t;

endpackage

[rtl/dense_layer_forward_backward_sgd_unit.sv]
// Fully connected layer with SGD training in signed Q4.12. A load of a weight
// or a bias, or a forward element that is not last, is stored directly; the
// last forward element starts OUT_SIZE dot products on a single
// multiply-accumulate unit fed from the weight memory. The last backward
// element computes the IN_SIZE sums of the input gradient, then a weight
// update (one weight per cycle through the memory) and a bias update.
// Output back-pressure stalls the unit while a result is held back. After
// reset a clearing pass zeroes the weight memory, during which no item is
// taken; the step size may be written at any time while idle.
module dense_layer_forward_backward_sgd_unit #(
  parameter int unsigned IN_SIZE  = dlfb_pkg::IN_SIZE_DEF,
  parameter int unsigned OUT_SIZE = dlfb_pkg::OUT_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlfb_pkg::VAL_W-1:0]    cfg_wdata_i,    // step size, unsigned Q0.16
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // item_index [3:0], weight_column [7:4], value [23:8]
  input  logic [dlfb_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic [dlfb_pkg::OP_W-1:0]     s_axis_tuser,   // opcode [1:0]
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_index [3:0], result_value [19:4], zero [23:20]
  output logic [dlfb_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]                    m_axis_tuser,   // result_kind [0]
  output logic                          m_axis_tlast
);
  import dlfb_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;
  logic  accept_en;

  dlfb_front #(
    .IN_SIZE (IN_SIZE),
    .OUT_SIZE(OUT_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_en_i  (accept_en),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  dlfb_back #(
    .IN_SIZE (IN_SIZE),
    .OUT_SIZE(OUT_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .accept_en_o  (accept_en),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

[rtl/dlfb_front.sv]
module dlfb_front #(
  parameter int unsigned IN_SIZE  = dlfb_pkg::IN_SIZE_DEF,
  parameter int unsigned OUT_SIZE = dlfb_pkg::OUT_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_en_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dlfb_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  logic [dlfb_pkg::OP_W-1:0]       s_axis_tuser,
  input  logic                            s_axis_tlast,
  output dlfb_pkg::item_t                 item_o,
  output logic                            item_valid_o,
  input  logic                            item_pop_i
);
  import dlfb_pkg::*;

  item_t      cls;
  item_t      q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  always_comb begin
    cls.op    = s_axis_tuser;
    cls.idx   = s_axis_tdata[3:0];
    cls.col   = s_axis_tdata[7:4];
    cls.value = $signed(s_axis_tdata[23:8]);
    cls.last  = s_axis_tlast;
    case (s_axis_tuser)
      OP_LOAD_W: cls.hit = (32'(cls.idx) < IN_SIZE) && (32'(cls.col) < OUT_SIZE);
      OP_LOAD_B: cls.hit = 32'(cls.idx) < OUT_SIZE;
      OP_FWD:    cls.hit = 32'(cls.idx) < IN_SIZE;
      default:   cls.hit = 32'(cls.idx) < OUT_SIZE;
    endcase
  end

  assign s_axis_tready = accept_en_i && (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = count_q != 2'd0;
  assign pop           = item_pop_i && item_valid_o;
  assign item_o        = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

[rtl/dlfb_back.sv]
module dlfb_back #(
  parameter int unsigned IN_SIZE  = dlfb_pkg::IN_SIZE_DEF,
  parameter int unsigned OUT_SIZE = dlfb_pkg::OUT_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlfb_pkg::VAL_W-1:0]    cfg_wdata_i,
  input  dlfb_pkg::item_t               item_i,
  input  logic                          item_valid_i,
  output logic                          item_pop_o,
  output logic                          accept_en_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dlfb_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);
  import dlfb_pkg::*;

  localparam int unsigned NW    = IN_SIZE * OUT_SIZE;
  localparam int unsigned AW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned IW    = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int unsigned OW    = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
  localparam int unsigned MAXD  = (IN_SIZE > OUT_SIZE) ? IN_SIZE : OUT_SIZE;
  localparam int unsigned CW    = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int unsigned ACC_W = 34 + CW;
  localparam int unsigned WW    = 52;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_BIAS  = 3'd5;

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [WW-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > WW'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -(WW'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  logic [2:0]              state_q, state_d;
  logic [VAL_W-1:0]        lr_q;
  logic signed [VAL_W-1:0] act_q  [IN_SIZE];
  logic signed [VAL_W-1:0] bias_q [OUT_SIZE];
  logic signed [VAL_W-1:0] grad_q [OUT_SIZE];
  logic [VAL_W-1:0]        wmem   [NW];
  logic [VAL_W-1:0]        rdata_q;

  logic [AW-1:0]           clr_q;
  logic                    bwd_q;
  logic [CW-1:0]           o_q, i_q;
  logic                    iss_done_q;
  logic                    v1_q, l1_q, v2_q, l2_q;
  logic signed [VAL_W-1:0] opnd_q;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;

  logic [IW-1:0]           ur_q;
  logic [OW-1:0]           uc_q;
  logic                    u1_v_q, u1_l_q, u2_v_q, u2_l_q;
  logic [AW-1:0]           u1_addr_q, u2_addr_q;
  logic signed [31:0]      ag_q;
  logic signed [48:0]      p2_q;
  logic [VAL_W-1:0]        w2_q;

  logic                    out_valid_q;
  logic                    out_kind_q, out_last_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic signed [VAL_W-1:0] out_val_q;

  logic                    out_free;
  logic [CW-1:0]           lim_in, lim_out;
  logic [CW-1:0]           row, col;
  logic [AW-1:0]           mac_addr, upd_addr, raddr, waddr, load_addr;
  logic                    we;
  logic [VAL_W-1:0]        wdata;
  logic                    issue, upd_issue;
  logic signed [WW-1:0]    mac_rnd, w_x, w_rnd, b_x, b_rnd;
  logic [CW-1:0]           o_next;

  assign accept_en_o = state_q != ST_CLEAR;
  assign item_pop_o  = (state_q == ST_IDLE) && item_valid_i;
  assign out_free    = !out_valid_q || m_axis_tready;

  always_comb begin
    lim_in    = bwd_q ? CW'(OUT_SIZE - 1) : CW'(IN_SIZE - 1);
    lim_out   = bwd_q ? CW'(IN_SIZE - 1) : CW'(OUT_SIZE - 1);
    row       = bwd_q ? o_q : i_q;
    col       = bwd_q ? i_q : o_q;
    o_next    = o_q + CW'(1);
    mac_addr  = AW'(32'(row) * OUT_SIZE + 32'(col));
    upd_addr  = AW'(32'(ur_q) * OUT_SIZE + 32'(uc_q));
    load_addr = AW'(32'(item_i.idx) * OUT_SIZE + 32'(item_i.col));
    raddr     = (state_q == ST_UPD) ? upd_addr : mac_addr;
    issue     = (state_q == ST_MAC) && !iss_done_q;
    upd_issue = (state_q == ST_UPD) && !iss_done_q;

    mac_rnd = (WW'(acc_q) + (WW'(1) <<< 11)) >>> 12;
    w_x     = (WW'($signed(w2_q)) <<< 28) - WW'(p2_q);
    w_rnd   = (w_x + (WW'(1) <<< 27)) >>> 28;
    b_x     = (WW'(bias_q[OW'(o_q)]) <<< 16)
              - WW'(grad_q[OW'(o_q)] * $signed({1'b0, lr_q}));
    b_rnd   = (b_x + (WW'(1) <<< 15)) >>> 16;

    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
    end else if (item_pop_o && item_i.op == OP_LOAD_W && item_i.hit) begin
      we    = 1'b1;
      waddr = load_addr;
      wdata = item_i.value;
    end else if (u2_v_q) begin
      we    = 1'b1;
      waddr = u2_addr_q;
      wdata = sat16(w_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      wmem[waddr] <= wdata;
    end
    rdata_q <= wmem[raddr];
  end

  // Pipeline payload: multiply stages and the gradient buffer, which is never cleared.
  always_ff @(posedge clk_i) begin
    opnd_q    <= bwd_q ? grad_q[OW'(i_q)] : act_q[IW'(i_q)];
    prod_q    <= opnd_q * $signed(rdata_q);
    u1_addr_q <= upd_addr;
    ag_q      <= act_q[ur_q] * grad_q[uc_q];
    u2_addr_q <= u1_addr_q;
    w2_q      <= rdata_q;
    p2_q      <= ag_q * $signed({1'b0, lr_q});
    if (item_pop_o && item_i.op == OP_BWD && item_i.hit) begin
      grad_q[OW'(item_i.idx)] <= item_i.value;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(NW - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (item_pop_o && item_i.last && (item_i.op == OP_FWD || item_i.op == OP_BWD)) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC:  if (v2_q && l2_q) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (o_q != lim_out) state_d = ST_MAC;
          else if (bwd_q) state_d = ST_UPD;
          else state_d = ST_IDLE;
        end
      end
      ST_UPD:  if (u2_v_q && u2_l_q) state_d = ST_BIAS;
      ST_BIAS: if (o_q == CW'(OUT_SIZE - 1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      lr_q        <= LR_RESET;
      clr_q       <= '0;
      bwd_q       <= 1'b0;
      o_q         <= '0;
      i_q         <= '0;
      iss_done_q  <= 1'b0;
      v1_q        <= 1'b0;
      l1_q        <= 1'b0;
      v2_q        <= 1'b0;
      l2_q        <= 1'b0;
      acc_q       <= '0;
      ur_q        <= '0;
      uc_q        <= '0;
      u1_v_q      <= 1'b0;
      u1_l_q      <= 1'b0;
      u2_v_q      <= 1'b0;
      u2_l_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_FWD;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      for (int k = 0; k < IN_SIZE; k++) act_q[k] <= '0;
      for (int k = 0; k < OUT_SIZE; k++) bias_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) lr_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);

      v1_q   <= issue;
      l1_q   <= issue && (i_q == lim_in);
      v2_q   <= v1_q;
      l2_q   <= l1_q;
      u1_v_q <= upd_issue;
      u1_l_q <= upd_issue && (ur_q == IW'(IN_SIZE - 1)) && (uc_q == OW'(OUT_SIZE - 1));
      u2_v_q <= u1_v_q;
      u2_l_q <= u1_l_q;

      if (m_axis_tready && !(state_q == ST_EMIT && out_free)) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (item_pop_o) begin
            if (item_i.op == OP_LOAD_B && item_i.hit) begin
              bias_q[OW'(item_i.idx)] <= item_i.value;
            end
            if (item_i.op == OP_FWD && item_i.hit) begin
              act_q[IW'(item_i.idx)] <= item_i.value;
            end
            bwd_q      <= item_i.op == OP_BWD;
            o_q        <= '0;
            i_q        <= '0;
            iss_done_q <= 1'b0;
            acc_q      <= (item_i.op == OP_BWD) ? '0 : (ACC_W'(bias_q[0]) <<< 12);
          end
        end
        ST_MAC: begin
          if (issue) begin
            if (i_q == lim_in) iss_done_q <= 1'b1;
            else i_q <= i_q + CW'(1);
          end
          if (v2_q) acc_q <= acc_q + ACC_W'(prod_q);
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= bwd_q ? KIND_BWD : KIND_FWD;
            out_idx_q   <= IDX_W'(o_q);
            out_val_q   <= sat16(mac_rnd);
            out_last_q  <= o_q == lim_out;
            o_q         <= (o_q == lim_out) ? '0 : o_next;
            i_q         <= '0;
            iss_done_q  <= 1'b0;
            ur_q        <= '0;
            uc_q        <= '0;
            acc_q       <= bwd_q ? '0 : (ACC_W'(bias_q[OW'(o_next)]) <<< 12);
          end
        end
        ST_UPD: begin
          if (upd_issue) begin
            if (uc_q == OW'(OUT_SIZE - 1)) begin
              uc_q <= '0;
              if (ur_q == IW'(IN_SIZE - 1)) iss_done_q <= 1'b1;
              else ur_q <= ur_q + IW'(1);
            end else begin
              uc_q <= uc_q + OW'(1);
            end
          end
        end
        ST_BIAS: begin
          bias_q[OW'(o_q)] <= sat16(b_rnd);
          o_q              <= o_next;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, out_val_q, out_idx_q};

endmodule
